>>> rtl/core/rmm2d_pkg.sv
`timescale 1ns / 1ps

package rmm2d_pkg;

    localparam int CFG_INDEX_WIDTH = 4;
    localparam int SIZE_WIDTH      = 7;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROWS_IN_USE = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COLS_IN_USE = 4'd1;

    localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = 7'd64;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [6:0]         row;
        logic [6:0]         col;
        logic signed [31:0] new_value;
        logic [6:0]         row_lo;
        logic [6:0]         row_hi;
        logic [6:0]         col_lo;
        logic [6:0]         col_hi;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] range_max;
        logic signed [31:0] range_min;
        logic               empty_range;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RDESC,
        S_CDESC,
        S_URA,
        S_URB,
        S_UWR,
        S_QROW,
        S_QCOL,
        S_QDONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic dispatch;
        logic rdesc;
        logic cdesc;
        logic u_rda;
        logic u_rdb;
        logic u_wr;
        logic q_row;
        logic q_col;
        logic q_out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic mode;
        logic upd_ok;
        logic q_empty;
        logic rd_leaf;
        logic cd_leaf;
        logic asc_last;
        logic rs_empty;
        logic r_cov;
        logic cs_empty;
        logic out_busy;
    } sts_t;

endpackage

>>> rtl/core/rmm2d_ram.sv
`timescale 1ns / 1ps

module rmm2d_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/rmm2d_ctrl.sv
`timescale 1ns / 1ps

module rmm2d_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rmm2d_pkg::sts_t   sts,
    output rmm2d_pkg::cmd_t   cmd
);
    import rmm2d_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (sts.mode == MODE_UPDATE) begin
                    state_next = sts.upd_ok ? S_RDESC : S_IDLE;
                end else begin
                    state_next = sts.q_empty ? S_QDONE : S_QROW;
                end
            end
            S_RDESC: begin
                if (sts.rd_leaf) state_next = S_CDESC;
            end
            S_CDESC: begin
                if (sts.cd_leaf) state_next = S_URA;
            end
            S_URA: state_next = S_URB;
            S_URB: state_next = S_UWR;
            S_UWR: begin
                state_next = sts.asc_last ? S_IDLE : S_URA;
            end
            S_QROW: begin
                if (sts.rs_empty) begin
                    state_next = S_QDONE;
                end else if (sts.r_cov) begin
                    state_next = S_QCOL;
                end
            end
            S_QCOL: begin
                if (sts.cs_empty) state_next = S_QROW;
            end
            S_QDONE: begin
                if (!sts.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR:    cmd.clr_step = 1'b1;
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_DISPATCH: cmd.dispatch = 1'b1;
            S_RDESC:    cmd.rdesc = 1'b1;
            S_CDESC:    cmd.cdesc = 1'b1;
            S_URA:      cmd.u_rda = 1'b1;
            S_URB:      cmd.u_rdb = 1'b1;
            S_UWR:      cmd.u_wr = 1'b1;
            S_QROW:     cmd.q_row = !sts.rs_empty;
            S_QCOL:     cmd.q_col = !sts.cs_empty;
            S_QDONE:    cmd.q_out = !sts.out_busy;
            default:    cmd = '0;
        endcase
    end

endmodule

>>> rtl/core/rmm2d_dp.sv
`timescale 1ns / 1ps

module rmm2d_dp #(
    parameter int ROWS_MAX    = 64,
    parameter int COLS_MAX    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  rmm2d_pkg::cmd_t                        cmd,
    output rmm2d_pkg::sts_t                        sts,
    input  rmm2d_pkg::in_item_t                    s_item,
    input  logic                                   cfg_valid,
    input  logic [rmm2d_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [rmm2d_pkg::SIZE_WIDTH-1:0]       cfg_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output rmm2d_pkg::out_item_t                   m_item
);
    import rmm2d_pkg::*;

    localparam int VW   = VALUE_WIDTH;
    localparam int RW   = $clog2(ROWS_MAX);
    localparam int CW   = $clog2(COLS_MAX);
    localparam int RNW  = RW + 1;
    localparam int CNW  = CW + 1;
    localparam int AW   = RNW + CNW;
    localparam int LR   = RW + 1;
    localparam int LC   = CW + 1;
    localparam int RKW  = $clog2(LR);
    localparam int CKW  = $clog2(LC);
    localparam int RSD  = 2 * LR;
    localparam int CSD  = 2 * LC;
    localparam int RSIW = $clog2(RSD);
    localparam int CSIW = $clog2(CSD);
    localparam int RSPW = $clog2(RSD + 1);
    localparam int CSPW = $clog2(CSD + 1);

    function automatic logic [RNW-1:0] rid(input logic [RW-1:0] l, input logic [RW-1:0] r);
        logic [RNW-1:0] s;
        s = {1'b0, l} + {1'b0, r};
        return s | {{(RNW-1){1'b0}}, l != r};
    endfunction

    function automatic logic [CNW-1:0] cid(input logic [CW-1:0] l, input logic [CW-1:0] r);
        logic [CNW-1:0] s;
        s = {1'b0, l} + {1'b0, r};
        return s | {{(CNW-1){1'b0}}, l != r};
    endfunction

    function automatic logic [RW-1:0] rmid(input logic [RW-1:0] l, input logic [RW-1:0] r);
        logic [RW-1:0] d;
        d = r - l;
        return l + (d >> 1);
    endfunction

    function automatic logic [CW-1:0] cmid(input logic [CW-1:0] l, input logic [CW-1:0] r);
        logic [CW-1:0] d;
        d = r - l;
        return l + (d >> 1);
    endfunction

    // configuration and latched item
    logic [SIZE_WIDTH-1:0] rows_reg, cols_reg;
    in_item_t              in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= SIZE_RESET;
            cols_reg <= SIZE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ROWS_IN_USE) rows_reg <= cfg_data;
            if (cfg_index == CFG_COLS_IN_USE) cols_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) in_reg <= s_item;
    end

    // effective sizes, bounds check and query clipping
    logic [31:0] nrows, ncols, rlo, rhi, clo, chi;
    logic [31:0] row_w, col_w;
    logic        upd_ok, q_empty;
    logic [RW-1:0] nrm1, ux, x1, x2;
    logic [CW-1:0] ncm1, uy, y1, y2;
    logic [VW+31:0] nv_ext;
    logic [VW-1:0]  uval;

    always_comb begin
        nrows = (rows_reg == '0) ? 32'd1 :
                ({25'd0, rows_reg} > 32'(ROWS_MAX)) ? 32'(ROWS_MAX) : {25'd0, rows_reg};
        ncols = (cols_reg == '0) ? 32'd1 :
                ({25'd0, cols_reg} > 32'(COLS_MAX)) ? 32'(COLS_MAX) : {25'd0, cols_reg};
        row_w = {25'd0, in_reg.row};
        col_w = {25'd0, in_reg.col};
        upd_ok = (row_w != 32'd0) && (row_w <= nrows) && (col_w != 32'd0) && (col_w <= ncols);
        rlo = (in_reg.row_lo == '0) ? 32'd1 : {25'd0, in_reg.row_lo};
        clo = (in_reg.col_lo == '0) ? 32'd1 : {25'd0, in_reg.col_lo};
        rhi = ({25'd0, in_reg.row_hi} > nrows) ? nrows : {25'd0, in_reg.row_hi};
        chi = ({25'd0, in_reg.col_hi} > ncols) ? ncols : {25'd0, in_reg.col_hi};
        q_empty = (rlo > rhi) || (clo > chi);
        nrm1 = RW'(nrows - 32'd1);
        ncm1 = CW'(ncols - 32'd1);
        ux   = RW'(row_w - 32'd1);
        uy   = CW'(col_w - 32'd1);
        x1   = RW'(rlo - 32'd1);
        x2   = RW'(rhi - 32'd1);
        y1   = CW'(clo - 32'd1);
        y2   = CW'(chi - 32'd1);
        nv_ext = {{VW{1'b0}}, in_reg.new_value};
        uval   = nv_ext[VW-1:0];
    end

    logic [RW-1:0] x1_reg, x2_reg;
    logic [CW-1:0] y1_reg, y2_reg;
    logic          empty_reg;

    always_ff @(posedge aclk) begin
        if (cmd.dispatch) begin
            x1_reg    <= x1;
            x2_reg    <= x2;
            y1_reg    <= y1;
            y2_reg    <= y2;
            empty_reg <= q_empty;
        end
    end

    // node store: {max, min}
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [2*VW-1:0]  ram_wdata, ram_rdata;

    rmm2d_ram #(
        .WIDTH (2 * VW),
        .DEPTH (1 << AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // clearing sweep
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // update: path descent
    logic [RW-1:0]  rpath_l_reg [LR];
    logic [RW-1:0]  rpath_r_reg [LR];
    logic [CW-1:0]  cpath_l_reg [LC];
    logic [CW-1:0]  cpath_r_reg [LC];
    logic [RW-1:0]  rd_l_reg, rd_r_reg;
    logic [CW-1:0]  cd_l_reg, cd_r_reg;
    logic [RKW-1:0] rk_reg, rdepth_reg;
    logic [CKW-1:0] ck_reg, cdepth_reg;
    logic [RW-1:0]  rd_m;
    logic [CW-1:0]  cd_m;

    assign rd_m = rmid(rd_l_reg, rd_r_reg);
    assign cd_m = cmid(cd_l_reg, cd_r_reg);

    always_ff @(posedge aclk) begin
        if (cmd.dispatch) begin
            rd_l_reg <= '0;
            rd_r_reg <= nrm1;
            rk_reg   <= '0;
        end else if (cmd.rdesc) begin
            rpath_l_reg[rk_reg] <= rd_l_reg;
            rpath_r_reg[rk_reg] <= rd_r_reg;
            if (rd_l_reg == rd_r_reg) begin
                rdepth_reg <= rk_reg;
                cd_l_reg   <= '0;
                cd_r_reg   <= ncm1;
                ck_reg     <= '0;
            end else begin
                rk_reg <= rk_reg + RKW'(1);
                if (ux <= rd_m) begin
                    rd_r_reg <= rd_m;
                end else begin
                    rd_l_reg <= rd_m + RW'(1);
                end
            end
        end else if (cmd.cdesc) begin
            cpath_l_reg[ck_reg] <= cd_l_reg;
            cpath_r_reg[ck_reg] <= cd_r_reg;
            if (cd_l_reg == cd_r_reg) begin
                cdepth_reg <= ck_reg;
            end else begin
                ck_reg <= ck_reg + CKW'(1);
                if (uy <= cd_m) begin
                    cd_r_reg <= cd_m;
                end else begin
                    cd_l_reg <= cd_m + CW'(1);
                end
            end
        end else if (cmd.u_wr) begin
            if (ck_reg != '0) begin
                ck_reg <= ck_reg - CKW'(1);
            end else begin
                ck_reg <= cdepth_reg;
                if (rk_reg != '0) rk_reg <= rk_reg - RKW'(1);
            end
        end
    end

    // update: bottom-up rebuild addressing
    logic [RW-1:0]  a_rl, a_rr, a_rm;
    logic [CW-1:0]  a_cl, a_cr, a_cm;
    logic [RNW-1:0] a_xn, a_xa, a_xb;
    logic [CNW-1:0] a_cn, a_ca, a_cb;
    logic           a_cleaf, a_direct;
    logic [AW-1:0]  addr_a, addr_b, addr_w;

    always_comb begin
        a_rl = rpath_l_reg[rk_reg];
        a_rr = rpath_r_reg[rk_reg];
        a_rm = rmid(a_rl, a_rr);
        a_cl = cpath_l_reg[ck_reg];
        a_cr = cpath_r_reg[ck_reg];
        a_cm = cmid(a_cl, a_cr);
        a_xn = rid(a_rl, a_rr);
        a_xa = rid(a_rl, a_rm);
        a_xb = rid(a_rm + RW'(1), a_rr);
        a_cn = cid(a_cl, a_cr);
        a_ca = cid(a_cl, a_cm);
        a_cb = cid(a_cm + CW'(1), a_cr);
        a_cleaf  = (a_cl == a_cr);
        a_direct = (a_rl == a_rr) && a_cleaf;
        // a column leaf of an inner row node merges the two child rows
        addr_a = a_cleaf ? {a_xa, a_cn} : {a_xn, a_ca};
        addr_b = a_cleaf ? {a_xb, a_cn} : {a_xn, a_cb};
        addr_w = {a_xn, a_cn};
    end

    logic [2*VW-1:0] hold_reg;
    logic [VW-1:0]   h_max, h_min, d_max, d_min, m_max, m_min;

    always_ff @(posedge aclk) begin
        if (cmd.u_rdb) hold_reg <= ram_rdata;
    end

    always_comb begin
        h_max = hold_reg[2*VW-1:VW];
        h_min = hold_reg[VW-1:0];
        d_max = ram_rdata[2*VW-1:VW];
        d_min = ram_rdata[VW-1:0];
        m_max = ($signed(h_max) > $signed(d_max)) ? h_max : d_max;
        m_min = ($signed(h_min) > $signed(d_min)) ? d_min : h_min;
    end

    // query: row and column traversal stacks
    logic [RW-1:0]   rs_l_reg [RSD];
    logic [RW-1:0]   rs_r_reg [RSD];
    logic [CW-1:0]   cs_l_reg [CSD];
    logic [CW-1:0]   cs_r_reg [CSD];
    logic [RSPW-1:0] rsp_reg;
    logic [CSPW-1:0] csp_reg;
    logic [RNW-1:0]  qrow_reg;
    logic [RSIW-1:0] rtop, rpush;
    logic [CSIW-1:0] ctop, cpush;
    logic [RW-1:0]   q_rl, q_rr, q_rm;
    logic [CW-1:0]   q_cl, q_cr, q_cm;
    logic            r_cov, r_gol, r_gor, c_cov, c_gol, c_gor;

    always_comb begin
        rtop  = RSIW'(rsp_reg - RSPW'(1));
        rpush = RSIW'(rsp_reg);
        ctop  = CSIW'(csp_reg - CSPW'(1));
        cpush = CSIW'(csp_reg);
        q_rl  = rs_l_reg[rtop];
        q_rr  = rs_r_reg[rtop];
        q_rm  = rmid(q_rl, q_rr);
        q_cl  = cs_l_reg[ctop];
        q_cr  = cs_r_reg[ctop];
        q_cm  = cmid(q_cl, q_cr);
        r_cov = (x1_reg <= q_rl) && (q_rr <= x2_reg);
        r_gol = (x1_reg <= q_rm);
        r_gor = (q_rm < x2_reg);
        c_cov = (y1_reg <= q_cl) && (q_cr <= y2_reg);
        c_gol = (y1_reg <= q_cm);
        c_gor = (q_cm < y2_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.dispatch) begin
            rs_l_reg[0] <= '0;
            rs_r_reg[0] <= nrm1;
        end else if (cmd.q_row) begin
            if (r_cov) begin
                qrow_reg    <= rid(q_rl, q_rr);
                cs_l_reg[0] <= '0;
                cs_r_reg[0] <= ncm1;
            end else if (r_gol && r_gor) begin
                rs_l_reg[rtop]  <= q_rm + RW'(1);
                rs_r_reg[rtop]  <= q_rr;
                rs_l_reg[rpush] <= q_rl;
                rs_r_reg[rpush] <= q_rm;
            end else if (r_gol) begin
                rs_r_reg[rtop] <= q_rm;
            end else if (r_gor) begin
                rs_l_reg[rtop] <= q_rm + RW'(1);
            end
        end else if (cmd.q_col && !c_cov) begin
            if (c_gol && c_gor) begin
                cs_l_reg[ctop]  <= q_cm + CW'(1);
                cs_r_reg[ctop]  <= q_cr;
                cs_l_reg[cpush] <= q_cl;
                cs_r_reg[cpush] <= q_cm;
            end else if (c_gol) begin
                cs_r_reg[ctop] <= q_cm;
            end else if (c_gor) begin
                cs_l_reg[ctop] <= q_cm + CW'(1);
            end
        end
    end

    logic [RSPW-1:0] rsp_next;
    logic [CSPW-1:0] csp_next;

    always_comb begin
        rsp_next = rsp_reg;
        csp_next = csp_reg;
        if (cmd.dispatch) begin
            rsp_next = RSPW'(1);
        end else if (cmd.q_row) begin
            if (r_cov) begin
                rsp_next = rsp_reg - RSPW'(1);
                csp_next = CSPW'(1);
            end else if (r_gol && r_gor) begin
                rsp_next = rsp_reg + RSPW'(1);
            end else if (!r_gol && !r_gor) begin
                rsp_next = rsp_reg - RSPW'(1);
            end
        end else if (cmd.q_col) begin
            if (c_cov || (!c_gol && !c_gor)) begin
                csp_next = csp_reg - CSPW'(1);
            end else if (c_gol && c_gor) begin
                csp_next = csp_reg + CSPW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_reg <= '0;
            csp_reg <= '0;
        end else begin
            rsp_reg <= rsp_next;
            csp_reg <= csp_next;
        end
    end

    // accumulate each covering node in the cycle after its read
    logic          acc_en_reg;
    logic [VW-1:0] acc_max_reg, acc_min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= cmd.q_col && c_cov;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dispatch) begin
            acc_max_reg <= {1'b1, {(VW-1){1'b0}}};
            acc_min_reg <= {1'b0, {(VW-1){1'b1}}};
        end else if (acc_en_reg) begin
            if ($signed(d_max) > $signed(acc_max_reg)) acc_max_reg <= d_max;
            if ($signed(acc_min_reg) > $signed(d_min)) acc_min_reg <= d_min;
        end
    end

    // RAM port steering
    always_comb begin
        ram_we    = cmd.clr_step || cmd.u_wr;
        ram_waddr = cmd.clr_step ? clr_addr_reg : addr_w;
        if (cmd.clr_step) begin
            ram_wdata = '0;
        end else if (a_direct) begin
            ram_wdata = {uval, uval};
        end else begin
            ram_wdata = {m_max, m_min};
        end
        if (cmd.u_rda) begin
            ram_raddr = addr_a;
        end else if (cmd.u_rdb) begin
            ram_raddr = addr_b;
        end else begin
            ram_raddr = {qrow_reg, cid(q_cl, q_cr)};
        end
    end

    // result register
    logic           out_valid_reg;
    out_item_t      out_reg;
    logic [VW+31:0] ext_max, ext_min;

    assign ext_max = {32'd0, acc_max_reg};
    assign ext_min = {32'd0, acc_min_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.q_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.q_out) begin
            out_reg.range_max   <= ext_max[31:0];
            out_reg.range_min   <= ext_min[31:0];
            out_reg.empty_range <= empty_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    always_comb begin
        sts.clr_last = &clr_addr_reg;
        sts.mode     = in_reg.mode;
        sts.upd_ok   = upd_ok;
        sts.q_empty  = q_empty;
        sts.rd_leaf  = (rd_l_reg == rd_r_reg);
        sts.cd_leaf  = (cd_l_reg == cd_r_reg);
        sts.asc_last = (rk_reg == '0) && (ck_reg == '0);
        sts.rs_empty = (rsp_reg == '0);
        sts.r_cov    = r_cov;
        sts.cs_empty = (csp_reg == '0);
        sts.out_busy = out_valid_reg && !m_ready;
    end

    a_rsp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_reg <= RSPW'(RSD))
        else $error("row stack overflow");

    a_csp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        csp_reg <= CSPW'(CSD))
        else $error("column stack overflow");

    a_acc_src: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_en_reg |-> $past(cmd.q_col))
        else $error("accumulate without a column read");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(cmd.q_out))
        else $error("result raised without a finished query");

endmodule

>>> rtl/core/range_max_min_2d_segment_tree_core.sv
`timescale 1ns / 1ps

// Two-dimensional segment tree of signed maxima and minima over a grid of up
// to ROWS_MAX x COLS_MAX cells. mode 0 updates one cell and gives no result;
// mode 1 queries a rectangle and gives one result (range_max, range_min,
// empty_range). Every node visit goes through the single read port of the
// node store, so the block handles one item at a time. After reset the store
// is swept to zero, one entry per cycle over all 4 * ROWS_MAX' * COLS_MAX'
// entries (the sizes rounded up to powers of two, 16384 entries by default);
// no item is taken during the sweep, but configuration writes are. A finished
// result waits in the output register, and the next item is accepted
// meanwhile. Write rows_in_use / cols_in_use only while idle; resizing does
// not rebuild the store.
module range_max_min_2d_segment_tree_core #(
    parameter int ROWS_MAX    = 64,
    parameter int COLS_MAX    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  rmm2d_pkg::in_item_t                    s_item,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output rmm2d_pkg::out_item_t                   m_item,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rmm2d_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [rmm2d_pkg::SIZE_WIDTH-1:0]       cfg_data
);
    import rmm2d_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // size registers are always writable
    assign cfg_ready = 1'b1;

    // sequence clear, update and query walks
    rmm2d_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // hold the store, traversal stacks, accumulators and result register
    rmm2d_dp #(
        .ROWS_MAX    (ROWS_MAX),
        .COLS_MAX    (COLS_MAX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_item    (s_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
